>>> rtl/core/go_to_goal_p_controller_assert.svh
// Assertion macros for the go-to-goal controller checker.
`ifndef GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define GGPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset too.
`define GGPC_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ggpc_pkg.sv
// Shared constants, tables and types of the go-to-goal controller.
package ggpc_pkg;

    localparam int TABLE_LEN          = 24;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int GAIN_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int HEAD_W     = 17;  // Q4.13
    localparam int ZW         = 33;  // angle accumulator, Q.30
    localparam int ERR_W      = 18;
    localparam int LIN_W      = 24;
    localparam int ANG_W      = 21;

    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 4;

    localparam logic signed [HEAD_W-1:0] PI_Q13      = 17'sd25736;
    localparam logic signed [ERR_W-1:0]  TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [ZW-1:0]     HALF_PI_Q30 = 33'sd1686629713;
    localparam logic [23:0]              INV_K_Q24   = 24'd10188014;

    // atan(2^-i) in Q.30, rounded to nearest
    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    localparam logic [GAIN_W-1:0]     LINEAR_GAIN_RST  = 16'd4096;
    localparam logic [GAIN_W-1:0]     ANGULAR_GAIN_RST = 16'd12288;
    localparam logic [CFG_DATA_W-1:0] OFFSET_RST       = 16'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_GAIN  = 2'd0,
        REG_ANGULAR_GAIN = 2'd1,
        REG_OFFSET_X     = 2'd2,
        REG_OFFSET_Y     = 2'd3
    } t_reg_idx;

    // Sideband that travels with each vector down the cell row
    typedef struct packed {
        logic                     valid;
        logic                     zero;
        logic signed [HEAD_W-1:0] heading;
    } t_side;

    function automatic int stage_count(input int stages);
        return (stages > TABLE_LEN) ? TABLE_LEN : stages;
    endfunction

    function automatic int guard_bits(input int pos_w);
        return (pos_w < 28) ? 28 - pos_w : 0;
    endfunction

    // Width of the vector datapath in the cells
    function automatic int cordic_width(input int pos_w);
        return pos_w + 4 + guard_bits(pos_w);
    endfunction

    function automatic int latency(input int stages);
        return FRONT_STAGES + stage_count(stages) + BACK_STAGES;
    endfunction

endpackage

>>> rtl/core/ggpc_front.sv
// Front end: error vector, guard-bit scaling and quadrant pre-rotation.
module ggpc_front
    import ggpc_pkg::*;
#(
    parameter int POS_W = POSITION_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [POS_W-1:0]   i_target_x,
    input  logic signed [POS_W-1:0]   i_target_y,
    input  logic signed [POS_W-1:0]   i_pose_x,
    input  logic signed [POS_W-1:0]   i_pose_y,
    input  logic signed [HEAD_W-1:0]  i_pose_heading,
    input  logic [CFG_DATA_W-1:0]     i_offset_x,
    input  logic [CFG_DATA_W-1:0]     i_offset_y,
    output logic signed [cordic_width(POS_W)-1:0] o_x,
    output logic signed [cordic_width(POS_W)-1:0] o_y,
    output logic signed [ZW-1:0]      o_z,
    output t_side                     o_side
);

    localparam int G   = guard_bits(POS_W);
    localparam int EW  = POS_W + 2;
    localparam int CW  = cordic_width(POS_W);
    localparam int OXW = (POS_W > CFG_DATA_W) ? POS_W : CFG_DATA_W;

    logic [OXW-1:0]          off_x_z;
    logic [OXW-1:0]          off_y_z;
    logic signed [POS_W-1:0] off_x;
    logic signed [POS_W-1:0] off_y;

    logic                     r_valid1;
    logic signed [EW-1:0]     r_ex;
    logic signed [EW-1:0]     r_ey;
    logic signed [HEAD_W-1:0] r_head1;
    logic signed [EW-1:0]     n_ex;
    logic signed [EW-1:0]     n_ey;

    logic signed [CW-1:0]     sx;
    logic signed [CW-1:0]     sy;
    logic signed [CW-1:0]     n_x;
    logic signed [CW-1:0]     n_y;
    logic signed [ZW-1:0]     n_z;

    logic                     r_valid2;
    logic signed [CW-1:0]     r_x;
    logic signed [CW-1:0]     r_y;
    logic signed [ZW-1:0]     r_z;
    logic                     r_zero;
    logic signed [HEAD_W-1:0] r_head2;

    // offset register is zero-extended, then seen as a POS_W-bit signed value
    assign off_x_z = OXW'(i_offset_x);
    assign off_y_z = OXW'(i_offset_y);
    assign off_x   = off_x_z[POS_W-1:0];
    assign off_y   = off_y_z[POS_W-1:0];

    assign n_ex = EW'(i_target_x) - EW'(i_pose_x) + EW'(off_x);
    assign n_ey = EW'(i_target_y) - EW'(i_pose_y) + EW'(off_y);

    assign sx = CW'(r_ex) <<< G;
    assign sy = CW'(r_ey) <<< G;

    always_comb begin
        if (sx < 0) begin
            if (sy >= 0) begin
                n_x = sy;
                n_y = -sx;
                n_z = HALF_PI_Q30;
            end else begin
                n_x = -sy;
                n_y = sx;
                n_z = -HALF_PI_Q30;
            end
        end else begin
            n_x = sx;
            n_y = sy;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex    <= n_ex;
        r_ey    <= n_ey;
        r_head1 <= i_pose_heading;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_zero  <= (r_ex == '0) && (r_ey == '0);
        r_head2 <= r_head1;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = '{valid: r_valid2, zero: r_zero, heading: r_head2};

endmodule

>>> rtl/core/ggpc_cell.sv
// One vectoring CORDIC iteration with its pipeline register.
module ggpc_cell
    import ggpc_pkg::*;
#(
    parameter int CW  = cordic_width(POSITION_WIDTH_DEF),
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_side                i_side,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_side                o_side
);

    localparam logic signed [ZW-1:0] C_ATAN = ZW'(ATAN_Q30[IDX]);

    logic signed [CW-1:0]     xs;
    logic signed [CW-1:0]     ys;
    logic signed [CW-1:0]     n_x;
    logic signed [CW-1:0]     n_y;
    logic signed [ZW-1:0]     n_z;

    logic                     r_valid;
    logic signed [CW-1:0]     r_x;
    logic signed [CW-1:0]     r_y;
    logic signed [ZW-1:0]     r_z;
    logic                     r_zero;
    logic signed [HEAD_W-1:0] r_head;

    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    // drive y toward zero; y == 0 takes the minus branch
    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + C_ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - C_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_zero <= i_side.zero;
        r_head <= i_side.heading;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = '{valid: r_valid, zero: r_zero, heading: r_head};

endmodule

>>> rtl/core/ggpc_back.sv
// Back end: gain correction, angle wrap, gain products, rounding and saturation.
module ggpc_back
    import ggpc_pkg::*;
#(
    parameter int POS_W = POSITION_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [cordic_width(POS_W)-1:0] i_x,
    input  logic signed [ZW-1:0]                  i_z,
    input  t_side                                 i_side,
    input  logic [GAIN_W-1:0]                     i_linear_gain,
    input  logic [GAIN_W-1:0]                     i_angular_gain,
    output logic                                  o_valid,
    output logic [LIN_W-1:0]                      o_linear_velocity,
    output logic signed [ANG_W-1:0]               o_angular_velocity
);

    localparam int G   = guard_bits(POS_W);
    localparam int CW  = cordic_width(POS_W);
    localparam int XW  = CW - 2;           // magnitude bits of the final x
    localparam int PW  = XW + 24;
    localparam int DW  = POS_W + 3;
    localparam int LPW = GAIN_W + DW;
    localparam int LSW = LPW + 1 - 12;
    localparam int LCW = (LSW > LIN_W) ? LSW : LIN_W;
    localparam int AW  = GAIN_W + 1 + ERR_W;
    localparam int ASW = AW + 1 - 13;

    localparam logic [LIN_W-1:0]        LIN_MAX = '1;
    localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};
    localparam logic signed [ERR_W-1:0] PI_E    = ERR_W'(PI_Q13);
    localparam logic signed [ERR_W-1:0] NPI_E   = -PI_E;

    // stage 1
    logic [XW-1:0]            xp;
    logic signed [ZW-1:0]     zr;
    logic signed [ERR_W-1:0]  head_e;
    logic                     r_v1;
    logic [PW-1:0]            r_prod;
    logic signed [HEAD_W-1:0] r_bear;
    logic signed [ERR_W-1:0]  r_head;

    // stage 2
    logic [PW:0]              dsum;
    logic signed [ERR_W-1:0]  diff;
    logic signed [ERR_W-1:0]  n_err;
    logic                     r_v2;
    logic [DW-1:0]            r_dist;
    logic signed [ERR_W-1:0]  r_err;

    // stage 3
    logic                     r_v3;
    logic [LPW-1:0]           r_lin_p;
    logic signed [AW-1:0]     r_ang_p;

    // stage 4
    logic [LPW:0]             lsum;
    logic [LSW-1:0]           lsh;
    logic signed [AW:0]       asum;
    logic signed [ASW-1:0]    ash;
    logic [LIN_W-1:0]         n_lin;
    logic signed [ANG_W-1:0]  n_ang;
    logic                     r_v4;
    logic [LIN_W-1:0]         r_lin;
    logic signed [ANG_W-1:0]  r_ang;

    assign xp     = (!i_side.zero && (i_x > 0)) ? XW'(i_x) : '0;
    assign zr     = i_z + (ZW'(1) <<< 16);
    assign head_e = ERR_W'(i_side.heading);

    assign dsum = (PW+1)'(r_prod) + ((PW+1)'(1) << (23 + G));
    assign diff = ERR_W'(r_bear) - r_head;

    // single wrap toward [-pi, pi]
    always_comb begin
        if (diff > PI_E) begin
            n_err = diff - TWO_PI_Q13;
        end else if (diff < NPI_E) begin
            n_err = diff + TWO_PI_Q13;
        end else begin
            n_err = diff;
        end
    end

    assign lsum = (LPW+1)'(r_lin_p) + (LPW+1)'(2048);
    assign lsh  = LSW'(lsum >> 12);
    assign asum = (AW+1)'(r_ang_p) + (AW+1)'(4096);
    assign ash  = ASW'(asum >>> 13);

    always_comb begin
        if (LCW'(lsh) > LCW'(LIN_MAX)) begin
            n_lin = LIN_MAX;
        end else begin
            n_lin = LIN_W'(lsh);
        end
        if (ash > ASW'(ANG_MAX)) begin
            n_ang = ANG_MAX;
        end else if (ash < ASW'(ANG_MIN)) begin
            n_ang = ANG_MIN;
        end else begin
            n_ang = ANG_W'(ash);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_side.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PW'(xp) * PW'(INV_K_Q24);
        r_bear  <= i_side.zero ? '0 : HEAD_W'(zr >>> 17);
        r_head  <= (i_side.heading > PI_Q13) ? head_e - TWO_PI_Q13 : head_e;
        r_dist  <= DW'(dsum >> (24 + G));
        r_err   <= n_err;
        r_lin_p <= LPW'(i_linear_gain) * LPW'(r_dist);
        r_ang_p <= AW'(signed'({1'b0, i_angular_gain})) * AW'(r_err);
        r_lin   <= n_lin;
        r_ang   <= n_ang;
    end

    assign o_valid            = r_v4;
    assign o_linear_velocity  = r_lin;
    assign o_angular_velocity = r_ang;

endmodule

>>> rtl/core/go_to_goal_p_controller.sv
// Top level of the go-to-goal proportional controller.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------------------
//   command  | start, busy                 | i_target_x/y, i_pose_x/y, i_pose_heading
//   result   | o_result_strobe (one cycle) | o_linear_velocity, o_angular_velocity
//   config   | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One command beat per cycle while busy is low; each result passes through the front end,
// the row of CORDIC cells (one per iteration, at most TABLE_LEN) and the back end.
// Synchronous reset clears the pipeline and loads the register defaults; busy is high
// during reset and the first cycle after it, low otherwise. Results cannot be stalled.
module go_to_goal_p_controller
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [POSITION_WIDTH-1:0] i_target_x,
    input  logic signed [POSITION_WIDTH-1:0] i_target_y,
    input  logic signed [POSITION_WIDTH-1:0] i_pose_x,
    input  logic signed [POSITION_WIDTH-1:0] i_pose_y,
    input  logic signed [HEAD_W-1:0]         i_pose_heading,
    output logic                             o_result_strobe,
    output logic [LIN_W-1:0]                 o_linear_velocity,
    output logic signed [ANG_W-1:0]          o_angular_velocity,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data
);

    localparam int NSTG = stage_count(CORDIC_STAGES);
    localparam int CW   = cordic_width(POSITION_WIDTH);

    logic                    r_busy;
    logic                    accept;
    logic [GAIN_W-1:0]       r_linear_gain;
    logic [GAIN_W-1:0]       r_angular_gain;
    logic [CFG_DATA_W-1:0]   r_offset_x;
    logic [CFG_DATA_W-1:0]   r_offset_y;

    logic signed [CW-1:0]    w_x    [NSTG+1];
    logic signed [CW-1:0]    w_y    [NSTG+1];
    logic signed [ZW-1:0]    w_z    [NSTG+1];
    t_side                   w_side [NSTG+1];

    assign busy        = r_busy || !i_rst_n;
    assign accept      = start && !busy;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_gain  <= LINEAR_GAIN_RST;
            r_angular_gain <= ANGULAR_GAIN_RST;
            r_offset_x     <= OFFSET_RST;
            r_offset_y     <= OFFSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LINEAR_GAIN:  r_linear_gain  <= i_cfg_data;
                REG_ANGULAR_GAIN: r_angular_gain <= i_cfg_data;
                REG_OFFSET_X:     r_offset_x     <= i_cfg_data;
                REG_OFFSET_Y:     r_offset_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ggpc_front #(
        .POS_W (POSITION_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_pose_x       (i_pose_x),
        .i_pose_y       (i_pose_y),
        .i_pose_heading (i_pose_heading),
        .i_offset_x     (r_offset_x),
        .i_offset_y     (r_offset_y),
        .o_x            (w_x[0]),
        .o_y            (w_y[0]),
        .o_z            (w_z[0]),
        .o_side         (w_side[0])
    );

    for (genvar k = 0; k < NSTG; k++) begin : g_cell
        ggpc_cell #(
            .CW  (CW),
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_side  (w_side[k]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    ggpc_back #(
        .POS_W (POSITION_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_x                (w_x[NSTG]),
        .i_z                (w_z[NSTG]),
        .i_side             (w_side[NSTG]),
        .i_linear_gain      (r_linear_gain),
        .i_angular_gain     (r_angular_gain),
        .o_valid            (o_result_strobe),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity)
    );

endmodule

>>> rtl/core/ggpc_checker.sv
// Port-level checker for the go-to-goal controller, bound to the top level.
`include "go_to_goal_p_controller_assert.svh"

module ggpc_checker
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_result_strobe
);

    localparam int LAT   = latency(CORDIC_STAGES);
    localparam int CNT_W = $clog2(LAT + 1);

    logic             acc;
    logic [CNT_W-1:0] r_since;

    assign acc = i_start && !i_busy;

    // cycles out of reset, saturating at the pipeline depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
        end else if (r_since != CNT_W'(LAT)) begin
            r_since <= r_since + 1'b1;
        end
    end

    `GGPC_ASSERT_IMP(a_busy_low, i_clk, i_rst_n, $past(i_rst_n), !i_busy, "busy after reset")
    `GGPC_ASSERT_IMP(a_beat_out, i_clk, i_rst_n, (r_since == CNT_W'(LAT)) && $past(acc, LAT), i_result_strobe, "result beat missing")
    `GGPC_ASSERT_IMP(a_no_extra, i_clk, i_rst_n, i_result_strobe, $past(acc, LAT), "result beat without command")
    `GGPC_ASSERT_NEXT(a_rst_flush, i_clk, !i_rst_n, !i_result_strobe, "strobe after reset")

endmodule

bind go_to_goal_p_controller ggpc_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_ggpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (start),
    .i_busy          (busy),
    .i_result_strobe (o_result_strobe)
);
